// ===== design/pns_pkg.sv =====
`default_nettype none
package pns_pkg;

  localparam int MaxNucleotides = 4096;
  localparam int StoreBytes     = (MaxNucleotides + 3) / 4;
  localparam int AddrW          = $clog2(StoreBytes);
  localparam int PosW           = 13;
  localparam int CodeW          = 2;
  localparam int OpW            = 3;
  localparam int StatusW        = 2;
  localparam int LaneCntW       = 3;

  localparam logic [PosW-1:0] MaxLen = PosW'(MaxNucleotides);

  typedef logic [OpW-1:0]     op_code_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [CodeW-1:0]   nuc_t;
  typedef logic [7:0]         byte_t;

  localparam op_code_t OP_INIT     = 3'd0;
  localparam op_code_t OP_WRITE    = 3'd1;
  localparam op_code_t OP_APPEND   = 3'd2;
  localparam op_code_t OP_READ     = 3'd3;
  localparam op_code_t OP_TRUNCATE = 3'd4;
  localparam op_code_t OP_COUNT    = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_MODIFY,
    S_READ,
    S_COUNT,
    S_FINISH
  } state_t;

  // code repeated in all four lanes
  function automatic byte_t fill_byte(nuc_t code);
    return {4{code}};
  endfunction

  // lane 0 sits in the high bits
  function automatic nuc_t code_at(byte_t b, logic [1:0] lane);
    nuc_t c;
    case (lane)
      2'd0:    c = b[7:6];
      2'd1:    c = b[5:4];
      2'd2:    c = b[3:2];
      default: c = b[1:0];
    endcase
    return c;
  endfunction

  function automatic byte_t put_code(byte_t b, logic [1:0] lane, nuc_t code);
    byte_t r;
    r = b;
    case (lane)
      2'd0:    r[7:6] = code;
      2'd1:    r[5:4] = code;
      2'd2:    r[3:2] = code;
      default: r[1:0] = code;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/pns_if.sv =====
`default_nettype none
interface pns_req_if;
  logic                          valid;
  logic                          ready;
  logic [pns_pkg::OpW-1:0]       op;
  logic [pns_pkg::PosW-1:0]      position;
  logic [pns_pkg::CodeW-1:0]     nucleotide;

  modport source (output valid, op, position, nucleotide, input ready);
  modport sink   (input valid, op, position, nucleotide, output ready);
endinterface

interface pns_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pns_pkg::CodeW-1:0]     read_value;
  logic [pns_pkg::PosW-1:0]      occurrences;
  logic [pns_pkg::PosW-1:0]      seq_length;
  logic [pns_pkg::StatusW-1:0]   status;

  modport source (output valid, read_value, occurrences, seq_length, status, input ready);
  modport sink   (input valid, read_value, occurrences, seq_length, status, output ready);
endinterface
`default_nettype wire

// ===== design/packed_nucleotide_store_unit.sv =====
// Request flow: truncate, unknown ops and rejected requests go from the execute
// step straight to finish; read passes through a store read step, and write and
// append through a byte read-modify-write on the single write and registered read
// store ports; init and count walk the store one byte per cycle over the new or
// current length. One request is in flight at a time; the next is taken only in idle.
// Reset clears the length and the control state; store contents are undefined.
`default_nettype none
module packed_nucleotide_store_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  pns_req_if.sink    req,
  pns_rsp_if.source  rsp
);

  localparam int AddrW = pns_pkg::AddrW;
  localparam int PosW  = pns_pkg::PosW;

  // Sequencer state
  pns_pkg::state_t state, state_next;

  // Latched request transaction
  pns_pkg::op_code_t op_r;
  logic [PosW-1:0]   pos_r;
  pns_pkg::nuc_t     code_r;

  // Working registers
  logic [PosW-1:0]   len, len_next;          // current sequence length
  logic [PosW-1:0]   target, target_next;    // nucleotide index for read/write
  logic [AddrW-1:0]  byte_idx, byte_idx_next;  // walk pointer for fill and count
  logic [AddrW-1:0]  last_byte, last_byte_next;
  logic [PosW-1:0]   occ, occ_next;          // running count accumulator
  pns_pkg::nuc_t     res_rv, res_rv_next;
  pns_pkg::status_t  res_status, res_status_next;

  // Store: 4 nucleotides per byte, single write and single registered read
  pns_pkg::byte_t store [pns_pkg::StoreBytes];
  pns_pkg::byte_t rdata;
  logic           mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  pns_pkg::byte_t mem_wdata;

  // Response register
  logic                  out_valid;
  pns_pkg::nuc_t         out_rv;
  logic [PosW-1:0]       out_occ;
  logic [PosW-1:0]       out_len;
  pns_pkg::status_t      out_status;

  // Decisions taken in the EXEC cycle
  logic [PosW-1:0] idx;
  logic [PosW-1:0] pos_m1, len_m1;
  logic            init_bad, wr_range, wr_full, rd_range;

  // Count datapath: the adder folds one byte's match count per cycle
  logic [pns_pkg::LaneCntW-1:0] lanes, lane_cnt;

  logic accept_req, load_out;

  assign accept_req = req.valid && req.ready;
  assign req.ready  = (state == pns_pkg::S_IDLE);
  assign load_out   = (state == pns_pkg::S_FINISH) && (!out_valid || rsp.ready);

  assign idx      = (op_r == pns_pkg::OP_APPEND) ? len : pos_r;
  assign pos_m1   = pos_r - PosW'(1);
  assign len_m1   = len - PosW'(1);
  assign init_bad = pos_r > pns_pkg::MaxLen;
  assign wr_range = idx > len;
  assign wr_full  = (idx == len) && (len >= pns_pkg::MaxLen);
  assign rd_range = pos_r >= len;

  // Partial last byte holds len mod 4 valid lanes
  assign lanes = ((byte_idx == last_byte) && (len[1:0] != 2'd0)) ?
                 {1'b0, len[1:0]} : pns_pkg::LaneCntW'(4);

  pns_lane_match u_match (
    .byte_data (rdata),
    .code      (code_r),
    .lanes     (lanes),
    .count     (lane_cnt)
  );

  // Next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      pns_pkg::S_IDLE: begin
        if (req.valid) state_next = pns_pkg::S_EXEC;
      end
      pns_pkg::S_EXEC: begin
        case (op_r)
          pns_pkg::OP_INIT:
            state_next = (init_bad || pos_r == '0) ? pns_pkg::S_FINISH : pns_pkg::S_FILL;
          pns_pkg::OP_WRITE, pns_pkg::OP_APPEND:
            state_next = (wr_range || wr_full) ? pns_pkg::S_FINISH : pns_pkg::S_MODIFY;
          pns_pkg::OP_READ:
            state_next = rd_range ? pns_pkg::S_FINISH : pns_pkg::S_READ;
          pns_pkg::OP_COUNT:
            state_next = (len == '0) ? pns_pkg::S_FINISH : pns_pkg::S_COUNT;
          default:
            state_next = pns_pkg::S_FINISH;
        endcase
      end
      pns_pkg::S_FILL, pns_pkg::S_COUNT: begin
        if (byte_idx == last_byte) state_next = pns_pkg::S_FINISH;
      end
      pns_pkg::S_MODIFY, pns_pkg::S_READ: begin
        state_next = pns_pkg::S_FINISH;
      end
      pns_pkg::S_FINISH: begin
        if (!out_valid || rsp.ready) state_next = pns_pkg::S_IDLE;
      end
      default: state_next = pns_pkg::S_IDLE;
    endcase
  end

  // Datapath and store control
  always_comb begin
    len_next        = len;
    target_next     = target;
    byte_idx_next   = byte_idx;
    last_byte_next  = last_byte;
    occ_next        = occ;
    res_rv_next     = res_rv;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_waddr       = byte_idx;
    mem_wdata       = pns_pkg::fill_byte(code_r);
    mem_raddr       = byte_idx + AddrW'(1);

    unique case (state)
      pns_pkg::S_EXEC: begin
        target_next     = idx;
        byte_idx_next   = '0;
        occ_next        = '0;
        res_rv_next     = '0;
        res_status_next = pns_pkg::ST_OK;
        mem_raddr       = idx[AddrW+1:2];
        case (op_r)
          pns_pkg::OP_INIT: begin
            last_byte_next = pos_m1[AddrW+1:2];
            if (init_bad) res_status_next = pns_pkg::ST_RANGE;
            else          len_next        = pos_r;
          end
          pns_pkg::OP_WRITE, pns_pkg::OP_APPEND: begin
            if (wr_range)     res_status_next = pns_pkg::ST_RANGE;
            else if (wr_full) res_status_next = pns_pkg::ST_FULL;
          end
          pns_pkg::OP_READ: begin
            if (rd_range) res_status_next = pns_pkg::ST_RANGE;
          end
          pns_pkg::OP_TRUNCATE: begin
            if (rd_range) res_status_next = pns_pkg::ST_RANGE;
            else          len_next        = pos_r + PosW'(1);
          end
          pns_pkg::OP_COUNT: begin
            last_byte_next = len_m1[AddrW+1:2];
            mem_raddr      = '0;
          end
          default: ;
        endcase
      end
      pns_pkg::S_FILL: begin
        mem_we        = 1'b1;
        byte_idx_next = byte_idx + AddrW'(1);
      end
      pns_pkg::S_MODIFY: begin
        mem_we    = 1'b1;
        mem_waddr = target[AddrW+1:2];
        mem_wdata = pns_pkg::put_code(rdata, target[1:0], code_r);
        if (target == len) len_next = len + PosW'(1);
      end
      pns_pkg::S_READ: begin
        res_rv_next = pns_pkg::code_at(rdata, target[1:0]);
      end
      pns_pkg::S_COUNT: begin
        occ_next      = occ + PosW'(lane_cnt);
        byte_idx_next = byte_idx + AddrW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pns_pkg::S_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      if (load_out)       out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_req) begin
      op_r   <= req.op;
      pos_r  <= req.position;
      code_r <= req.nucleotide;
    end
    target     <= target_next;
    byte_idx   <= byte_idx_next;
    last_byte  <= last_byte_next;
    occ        <= occ_next;
    res_rv     <= res_rv_next;
    res_status <= res_status_next;
    if (load_out) begin
      out_rv     <= res_rv;
      out_occ    <= occ;
      out_len    <= len;
      out_status <= res_status;
    end
  end

  // Store array
  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    rdata <= store[mem_raddr];
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_value  = out_rv;
  assign rsp.occurrences = out_occ;
  assign rsp.seq_length  = out_len;
  assign rsp.status      = out_status;

  // Length never grows past capacity
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    len <= pns_pkg::MaxLen)
    else $error("length above capacity");

  // No store writes while waiting for a request
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == pns_pkg::S_IDLE) |-> !mem_we)
    else $error("store written while idle");

  // A new response only comes out of the finish step
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == pns_pkg::S_FINISH))
    else $error("response raised outside finish");

  // Occurrence count is bounded by the reported length
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_occ <= out_len))
    else $error("count exceeds length");

  // An accepted request transaction goes straight to execution
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept_req |=> (state == pns_pkg::S_EXEC))
    else $error("accepted request not executed");

endmodule
`default_nettype wire

// ===== design/pns_lane_match.sv =====
`default_nettype none
// Counts lanes of one packed byte that hold the given code; only the
// first `lanes` lanes take part.
module pns_lane_match (
  input  wire pns_pkg::byte_t                   byte_data,
  input  wire pns_pkg::nuc_t                    code,
  input  wire logic [pns_pkg::LaneCntW-1:0]     lanes,
  output logic [pns_pkg::LaneCntW-1:0]          count
);

  always_comb begin
    count = '0;
    for (int k = 0; k < 4; k++) begin
      if ((pns_pkg::LaneCntW'(k) < lanes) &&
          (pns_pkg::code_at(byte_data, 2'(k)) == code)) begin
        count = count + pns_pkg::LaneCntW'(1);
      end
    end
  end

endmodule
`default_nettype wire
